@@ design/gps_pkg.sv @@
// Shared constants and types for the gravity particle step core.
// Used by the body table, the force unit and the top level; depends on nothing else.
`timescale 1ns / 1ps

package gps_pkg;

   // Body table size and the widths that follow from it.
   localparam int MAX_BODIES = 16;
   localparam int BODY_AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int COUNT_W    = $clog2(MAX_BODIES + 1);

   // Force accumulator width: a sum of up to MAX_BODIES terms below 2^33.
   localparam int ACC_W = 40;

   // Floor of the squared distance, 10.0 in Q16.16.
   localparam logic [48:0] MIN_DIST_SQ = 49'd655360;

   // Configuration port.
   localparam int CSR_AW = 4;

   localparam logic [1:0] CFG_GRAV   = 2'd0;
   localparam logic [1:0] CFG_STEP   = 2'd1;
   localparam logic [1:0] CFG_WIDTH  = 2'd2;
   localparam logic [1:0] CFG_HEIGHT = 2'd3;

   localparam logic [31:0] GRAV_RESET   = 32'd65536;
   localparam logic [31:0] STEP_RESET   = 32'd1092;
   localparam logic [12:0] WIDTH_RESET  = 13'd1280;
   localparam logic [12:0] HEIGHT_RESET = 13'd720;

   // Operation codes.
   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_LOAD    = 2'd1,
      OP_STEP    = 2'd2,
      OP_ADVANCE = 2'd3
   } op_type;

   // Input transaction.
   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [31:0]        mass;
      logic               active;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic               still_active;
      logic [3:0]         body_index;
      logic               last;
      logic               status;
   } rsp_type;

   // One entry of the body table.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [31:0]        weight;
   } body_type;

   // Force unit status and the signed force components of one body.
   typedef struct packed {
      logic               done;
      logic signed [33:0] tx;
      logic signed [33:0] ty;
   } force_rsp_type;

endpackage

@@ design/gps_body_mem.sv @@
// Body table storage: one write port and one read port with registered data.
// Depends on gps_pkg for the entry type and depth.
`timescale 1ns / 1ps

module gps_body_mem (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [gps_pkg::BODY_AW-1:0] wr_addr,
   input  gps_pkg::body_type        wr_data,
   input  logic                     rd_en,
   input  logic [gps_pkg::BODY_AW-1:0] rd_addr,
   output gps_pkg::body_type        rd_data
);

   gps_pkg::body_type store_ff [gps_pkg::MAX_BODIES];
   gps_pkg::body_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/gps_divider.sv @@
// Restoring unsigned divider, 64-bit dividend and divisor, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module gps_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  count_ff, count_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] div_ff, div_in;
   logic [64:0] shifted;
   logic [64:0] trial;

   // One shift and trial subtract per cycle.
   always_comb begin
      shifted  = {rem_ff, quo_ff[63]};
      trial    = shifted - {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 6'd63;
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         if (count_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/gps_force_unit.sv @@
// Force of one body on one point: squared distance, magnitude, square root, components.
// Depends on gps_pkg for types and on gps_divider for the shared divisions.
`timescale 1ns / 1ps

module gps_force_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      part_x,
   input  logic signed [31:0]      part_y,
   input  gps_pkg::body_type       body,
   input  logic [31:0]             grav_constant,
   output gps_pkg::force_rsp_type  result
);

   typedef enum logic [9:0] {
      F_IDLE   = 10'b00_0000_0001,
      F_MUL    = 10'b00_0000_0010,
      F_PREP   = 10'b00_0000_0100,
      F_WAIT_A = 10'b00_0000_1000,
      F_MUL_X  = 10'b00_0001_0000,
      F_GO_X   = 10'b00_0010_0000,
      F_DIV_X  = 10'b00_0100_0000,
      F_MUL_Y  = 10'b00_1000_0000,
      F_GO_Y   = 10'b01_0000_0000,
      F_DIV_Y  = 10'b10_0000_0000
   } fstate_type;

   fstate_type state_ff, state_in;
   logic        done_ff, done_in;

   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0] weight_ff, weight_in;
   logic [31:0] adx_ff, adx_in, ady_ff, ady_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;
   logic [63:0] sx_ff, sx_in, sy_ff, sy_in, gm_ff, gm_in;
   logic        ovf_ff, ovf_in;
   logic [30:0] a_ff, a_in;
   logic [32:0] dist_ff, dist_in;
   logic [62:0] prod_ff, prod_in;
   logic signed [33:0] tx_ff, tx_in, ty_ff, ty_in;

   logic [63:0] sq_n_ff, sq_n_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [63:0] sq_try;

   logic [32:0] negdx, negdy;
   logic [48:0] dsq_raw, dsq;
   logic [64:0] sum65;
   logic [63:0] sq_op;
   logic [33:0] qmag;

   logic        div_start;
   logic [63:0] div_dividend, div_divisor, div_quotient;
   logic        div_done;

   gps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Distance helpers used while preparing the magnitude and the square root.
   always_comb begin
      negdx   = 33'd0 - dx_ff;
      negdy   = 33'd0 - dy_ff;
      dsq_raw = {1'b0, sx_ff[63:16]} + {1'b0, sy_ff[63:16]};
      dsq     = (dsq_raw < gps_pkg::MIN_DIST_SQ) ? gps_pkg::MIN_DIST_SQ : dsq_raw;
      sum65   = {1'b0, sx_ff} + {1'b0, sy_ff};
      // When the exact sum overflows, the root of the quarter sum is doubled.
      sq_op   = sum65[64] ? ({2'b00, sx_ff[63:2]} + {2'b00, sy_ff[63:2]}) : sum65[63:0];
      qmag    = {1'b0, div_quotient[32:0]};
   end

   // Divider requests: magnitude first, then the x and y components.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = {1'b0, prod_ff};
      div_divisor  = {31'd0, dist_ff};
      case (state_ff)
         F_PREP: begin
            div_start    = 1'b1;
            div_dividend = gm_ff;
            div_divisor  = {15'd0, dsq};
         end
         F_GO_X, F_GO_Y: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Bit-serial integer square root, running beside the first division.
   always_comb begin
      sq_try    = sq_r_ff + sq_bit_ff;
      sq_n_in   = sq_n_ff;
      sq_r_in   = sq_r_ff;
      sq_bit_in = sq_bit_ff;
      if (state_ff == F_PREP) begin
         sq_n_in   = sq_op;
         sq_r_in   = '0;
         sq_bit_in = 64'h4000_0000_0000_0000;
      end else if (sq_bit_ff != 64'd0) begin
         if (sq_n_ff >= sq_try) begin
            sq_n_in = sq_n_ff - sq_try;
            sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
         end else begin
            sq_r_in = sq_r_ff >> 1;
         end
         sq_bit_in = sq_bit_ff >> 2;
      end
   end

   // Sequencer for one body.
   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      weight_in = weight_ff;
      adx_in    = adx_ff;
      ady_in    = ady_ff;
      negx_in   = negx_ff;
      negy_in   = negy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      gm_in     = gm_ff;
      ovf_in    = ovf_ff;
      a_in      = a_ff;
      dist_in   = dist_ff;
      prod_in   = prod_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               dx_in     = {body.x[31], body.x} - {part_x[31], part_x};
               dy_in     = {body.y[31], body.y} - {part_y[31], part_y};
               weight_in = body.weight;
               state_in  = F_MUL;
            end
         end
         F_MUL: begin
            negx_in = dx_ff[32];
            negy_in = dy_ff[32];
            adx_in  = dx_ff[32] ? negdx[31:0] : dx_ff[31:0];
            ady_in  = dy_ff[32] ? negdy[31:0] : dy_ff[31:0];
            sx_in   = 64'(adx_in) * 64'(adx_in);
            sy_in   = 64'(ady_in) * 64'(ady_in);
            gm_in   = 64'(grav_constant) * 64'(weight_ff);
            // A body at the point itself pulls with zero force.
            if (dx_ff == 33'sd0 && dy_ff == 33'sd0) begin
               tx_in    = '0;
               ty_in    = '0;
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else begin
               state_in = F_PREP;
            end
         end
         F_PREP: begin
            ovf_in   = sum65[64];
            state_in = F_WAIT_A;
         end
         F_WAIT_A: begin
            // The root finishes well before the 64-step division.
            if (div_done) begin
               a_in     = (div_quotient[63:31] != 33'd0) ? 31'h7FFF_FFFF : div_quotient[30:0];
               dist_in  = ovf_ff ? {sq_r_ff[31:0], 1'b0} : {1'b0, sq_r_ff[31:0]};
               state_in = F_MUL_X;
            end
         end
         F_MUL_X: begin
            prod_in  = 63'(a_ff) * 63'(adx_ff);
            state_in = F_GO_X;
         end
         F_GO_X: begin
            state_in = F_DIV_X;
         end
         F_DIV_X: begin
            if (div_done) begin
               tx_in    = negx_ff ? (34'sd0 - $signed(qmag)) : $signed(qmag);
               state_in = F_MUL_Y;
            end
         end
         F_MUL_Y: begin
            prod_in  = 63'(a_ff) * 63'(ady_ff);
            state_in = F_GO_Y;
         end
         F_GO_Y: begin
            state_in = F_DIV_Y;
         end
         F_DIV_Y: begin
            if (div_done) begin
               ty_in    = negy_ff ? (34'sd0 - $signed(qmag)) : $signed(qmag);
               done_in  = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         done_ff   <= 1'b0;
         sq_bit_ff <= '0;
      end else begin
         state_ff  <= state_in;
         done_ff   <= done_in;
         sq_bit_ff <= sq_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      weight_ff <= weight_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      negx_ff   <= negx_in;
      negy_ff   <= negy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      gm_ff     <= gm_in;
      ovf_ff    <= ovf_in;
      a_ff      <= a_in;
      dist_ff   <= dist_in;
      prod_ff   <= prod_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      sq_n_ff   <= sq_n_in;
      sq_r_ff   <= sq_r_in;
   end

   assign result.done = done_ff;
   assign result.tx   = tx_ff;
   assign result.ty   = ty_ff;

endmodule

@@ design/gravity_particle_step_core.sv @@
// Top level of the gravity particle step core: control sequencer, registers, result stage.
// Depends on gps_pkg, gps_body_mem and gps_force_unit.
`timescale 1ns / 1ps

// The per-body work of step particle and advance bodies is set by the force unit, whose
// single bit-serial divider runs three 64-step divisions per body while the square root
// overlaps the first; a body at the particle's exact position skips the divisions. The
// body table lives in a 16-entry memory that is read once per body visited and written
// back once per body during advance bodies; its contents are not cleared at reset, only
// the body count. A new transaction is taken while the previous result still waits in
// the output register.
module gravity_particle_step_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gps_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gps_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gps_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int CW = gps_pkg::COUNT_W;
   localparam int AW = gps_pkg::ACC_W;

   typedef enum logic [15:0] {
      ST_IDLE      = 16'h0001,
      ST_SELF_RD   = 16'h0002,
      ST_SELF_WAIT = 16'h0004,
      ST_READ      = 16'h0008,
      ST_WAIT      = 16'h0010,
      ST_FORCE     = 16'h0020,
      ST_SAT       = 16'h0040,
      ST_MUL_V     = 16'h0080,
      ST_VEL       = 16'h0100,
      ST_MUL_P     = 16'h0200,
      ST_POS       = 16'h0400,
      ST_KILL_D    = 16'h0800,
      ST_KILL_SQ   = 16'h1000,
      ST_KILL_CMP  = 16'h2000,
      ST_WRITE     = 16'h4000,
      ST_EMIT      = 16'h8000
   } state_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -50'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   // Magnitude of a signed 32-bit value as unsigned.
   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      logic [31:0] u;
      u = x;
      return x[31] ? (32'd0 - u) : u;
   endfunction

   // Add a signed, truncated-toward-zero scaled term to a 32-bit base.
   function automatic logic signed [31:0] apply_term(input logic signed [31:0] base,
                                                     input logic [63:0] prod,
                                                     input logic neg);
      logic signed [49:0] term;
      logic signed [49:0] sum;
      term = $signed({2'b00, prod[63:16]});
      if (neg) begin
         term = 50'sd0 - term;
      end
      sum = {{18{base[31]}}, base} + term;
      return sat32(sum);
   endfunction

   state_type state_ff, state_in;

   // Configuration registers.
   logic [31:0] grav_ff, grav_in, dt_ff, dt_in;
   logic [12:0] width_ff, width_in, height_ff, height_in;
   logic        csr_write;

   // Control.
   logic [CW-1:0] count_ff, count_in, idx_i_ff, idx_i_in, idx_j_ff, idx_j_in;
   logic          advance_ff, advance_in;
   logic          rsp_valid_ff, rsp_valid_in;
   gps_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Working payload.
   logic signed [31:0] px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic [31:0]        weight_ff, weight_in;
   logic signed [AW-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [63:0]        prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic               neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [32:0]        ex_ff, ex_in, ey_ff, ey_in;
   logic [59:0]        limsq_ff, limsq_in;
   logic               far_ff, far_in;
   logic [60:0]        sqsum_ff, sqsum_in;
   gps_pkg::rsp_type   res_ff, res_in;

   // Memory and force unit connections.
   logic                       mem_wr_en, mem_rd_en;
   logic [gps_pkg::BODY_AW-1:0] mem_wr_addr, mem_rd_addr;
   gps_pkg::body_type          mem_wr_data, mem_rd_data;
   logic                       force_start;
   gps_pkg::force_rsp_type     force_rsp;

   logic        accept, out_free, full;
   logic [CW-1:0] idx_i_next;
   logic [33:0] kdx, kdy, kndx, kndy;
   logic [14:0] lim3;
   logic [29:0] lim;

   gps_body_mem u_body_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   gps_force_unit u_force_unit (
      .clock         (clock),
      .reset         (reset),
      .start         (force_start),
      .part_x        (px_ff),
      .part_y        (py_ff),
      .body          (mem_rd_data),
      .grav_constant (grav_ff),
      .result        (force_rsp)
   );

   // Handshakes.
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign full       = (count_ff >= CW'(gps_pkg::MAX_BODIES));
   assign idx_i_next = idx_i_ff + CW'(1);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Configuration register write and read.
   always_comb begin
      grav_in   = grav_ff;
      dt_in     = dt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            gps_pkg::CFG_GRAV:   grav_in   = csr_pwdata;
            gps_pkg::CFG_STEP:   dt_in     = csr_pwdata;
            gps_pkg::CFG_WIDTH:  width_in  = csr_pwdata[12:0];
            gps_pkg::CFG_HEIGHT: height_in = csr_pwdata[12:0];
            default:             grav_in   = grav_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         gps_pkg::CFG_GRAV:   csr_prdata = grav_ff;
         gps_pkg::CFG_STEP:   csr_prdata = dt_ff;
         gps_pkg::CFG_WIDTH:  csr_prdata = {19'd0, width_ff};
         gps_pkg::CFG_HEIGHT: csr_prdata = {19'd0, height_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // Distance from the window center and the kill limit.
   always_comb begin
      kdx  = {{2{px_ff[31]}}, px_ff} - {6'd0, width_ff, 15'd0};
      kdy  = {{2{py_ff[31]}}, py_ff} - {6'd0, height_ff, 15'd0};
      kndx = 34'd0 - kdx;
      kndy = 34'd0 - kdy;
      lim3 = {2'b00, width_ff} + {1'b0, width_ff, 1'b0};
      lim  = {lim3, 15'd0};
   end

   // Memory port use: loads and write-back share the write port; the sequencer
   // never reads and writes in the same cycle, so no forwarding is needed.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[gps_pkg::BODY_AW-1:0];
      mem_wr_data.x      = req_data.pos_x;
      mem_wr_data.y      = req_data.pos_y;
      mem_wr_data.vx     = req_data.vel_x;
      mem_wr_data.vy     = req_data.vel_y;
      mem_wr_data.weight = req_data.mass;
      if (accept && req_data.operation == gps_pkg::OP_LOAD && !full) begin
         mem_wr_en = 1'b1;
      end else if (state_ff == ST_WRITE) begin
         mem_wr_en          = 1'b1;
         mem_wr_addr        = idx_i_ff[gps_pkg::BODY_AW-1:0];
         mem_wr_data.x      = px_ff;
         mem_wr_data.y      = py_ff;
         mem_wr_data.vx     = vx_ff;
         mem_wr_data.vy     = vy_ff;
         mem_wr_data.weight = weight_ff;
      end
   end

   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_j_ff[gps_pkg::BODY_AW-1:0];
      if (state_ff == ST_SELF_RD) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = idx_i_ff[gps_pkg::BODY_AW-1:0];
      end else if (state_ff == ST_READ && idx_j_ff != count_ff
                   && !(advance_ff && idx_j_ff == idx_i_ff)) begin
         mem_rd_en = 1'b1;
      end
   end

   assign force_start = (state_ff == ST_WAIT);

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      advance_in   = advance_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      weight_in    = weight_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      limsq_in     = limsq_ff;
      far_in       = far_ff;
      sqsum_in     = sqsum_ff;
      res_in       = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in      = '0;
               res_in.last = 1'b1;
               advance_in  = 1'b0;
               px_in       = req_data.pos_x;
               py_in       = req_data.pos_y;
               vx_in       = req_data.vel_x;
               vy_in       = req_data.vel_y;
               acc_x_in    = '0;
               acc_y_in    = '0;
               idx_j_in    = '0;
               case (req_data.operation)
                  gps_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_EMIT;
                  end
                  gps_pkg::OP_LOAD: begin
                     if (full) begin
                        res_in.status = 1'b1;
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                     state_in = ST_EMIT;
                  end
                  gps_pkg::OP_STEP: begin
                     if (!req_data.active) begin
                        // An inactive particle passes through unchanged.
                        res_in.new_pos_x = req_data.pos_x;
                        res_in.new_pos_y = req_data.pos_y;
                        res_in.new_vel_x = req_data.vel_x;
                        res_in.new_vel_y = req_data.vel_y;
                        state_in         = ST_EMIT;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  gps_pkg::OP_ADVANCE: begin
                     // An empty table gives no results at all.
                     if (count_ff != '0) begin
                        advance_in = 1'b1;
                        idx_i_in   = '0;
                        state_in   = ST_SELF_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SELF_RD: begin
            state_in = ST_SELF_WAIT;
         end
         ST_SELF_WAIT: begin
            px_in     = mem_rd_data.x;
            py_in     = mem_rd_data.y;
            vx_in     = mem_rd_data.vx;
            vy_in     = mem_rd_data.vy;
            weight_in = mem_rd_data.weight;
            acc_x_in  = '0;
            acc_y_in  = '0;
            idx_j_in  = '0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            if (idx_j_ff == count_ff) begin
               state_in = ST_SAT;
            end else if (advance_ff && idx_j_ff == idx_i_ff) begin
               // A body exerts no force on itself.
               idx_j_in = idx_j_ff + CW'(1);
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_FORCE;
         end
         ST_FORCE: begin
            if (force_rsp.done) begin
               acc_x_in = acc_x_ff + {{(AW - 34){force_rsp.tx[33]}}, force_rsp.tx};
               acc_y_in = acc_y_ff + {{(AW - 34){force_rsp.ty[33]}}, force_rsp.ty};
               idx_j_in = idx_j_ff + CW'(1);
               state_in = ST_READ;
            end
         end
         ST_SAT: begin
            ax_in    = sat32({{(50 - AW){acc_x_ff[AW-1]}}, acc_x_ff});
            ay_in    = sat32({{(50 - AW){acc_y_ff[AW-1]}}, acc_y_ff});
            state_in = ST_MUL_V;
         end
         ST_MUL_V: begin
            prod_x_in = 64'(mag32(ax_ff)) * 64'(dt_ff);
            prod_y_in = 64'(mag32(ay_ff)) * 64'(dt_ff);
            neg_x_in  = ax_ff[31];
            neg_y_in  = ay_ff[31];
            state_in  = ST_VEL;
         end
         ST_VEL: begin
            vx_in    = apply_term(vx_ff, prod_x_ff, neg_x_ff);
            vy_in    = apply_term(vy_ff, prod_y_ff, neg_y_ff);
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            prod_x_in = 64'(mag32(vx_ff)) * 64'(dt_ff);
            prod_y_in = 64'(mag32(vy_ff)) * 64'(dt_ff);
            neg_x_in  = vx_ff[31];
            neg_y_in  = vy_ff[31];
            state_in  = ST_POS;
         end
         ST_POS: begin
            px_in    = apply_term(px_ff, prod_x_ff, neg_x_ff);
            py_in    = apply_term(py_ff, prod_y_ff, neg_y_ff);
            state_in = advance_ff ? ST_WRITE : ST_KILL_D;
         end
         ST_KILL_D: begin
            ex_in    = kdx[33] ? kndx[32:0] : kdx[32:0];
            ey_in    = kdy[33] ? kndy[32:0] : kdy[32:0];
            limsq_in = 60'(lim) * 60'(lim);
            state_in = ST_KILL_SQ;
         end
         ST_KILL_SQ: begin
            far_in   = (ex_ff > {3'd0, lim}) || (ey_ff > {3'd0, lim});
            // Only meaningful when both offsets lie within the limit.
            sqsum_in = {1'b0, 60'(ex_ff[29:0]) * 60'(ex_ff[29:0])}
                     + {1'b0, 60'(ey_ff[29:0]) * 60'(ey_ff[29:0])};
            state_in = ST_KILL_CMP;
         end
         ST_KILL_CMP: begin
            res_in              = '0;
            res_in.new_pos_x    = px_ff;
            res_in.new_pos_y    = py_ff;
            res_in.new_vel_x    = vx_ff;
            res_in.new_vel_y    = vy_ff;
            res_in.still_active = !far_ff && (sqsum_ff <= {1'b0, limsq_ff});
            res_in.last         = 1'b1;
            state_in            = ST_EMIT;
         end
         ST_WRITE: begin
            res_in              = '0;
            res_in.new_pos_x    = px_ff;
            res_in.new_pos_y    = py_ff;
            res_in.new_vel_x    = vx_ff;
            res_in.new_vel_y    = vy_ff;
            res_in.still_active = 1'b1;
            res_in.body_index   = 4'(idx_i_ff);
            res_in.last         = (idx_i_next == count_ff);
            state_in            = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (advance_ff && idx_i_next != count_ff) begin
                  idx_i_in = idx_i_next;
                  state_in = ST_SELF_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         advance_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grav_ff      <= gps_pkg::GRAV_RESET;
         dt_ff        <= gps_pkg::STEP_RESET;
         width_ff     <= gps_pkg::WIDTH_RESET;
         height_ff    <= gps_pkg::HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         advance_ff   <= advance_in;
         rsp_valid_ff <= rsp_valid_in;
         grav_ff      <= grav_in;
         dt_ff        <= dt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_i_ff    <= idx_i_in;
      idx_j_ff    <= idx_j_in;
      rsp_data_ff <= rsp_data_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      weight_ff   <= weight_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      limsq_ff    <= limsq_in;
      far_ff      <= far_in;
      sqsum_ff    <= sqsum_in;
      res_ff      <= res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A load into a full table leaves the body count alone.
   a_full_load_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == gps_pkg::OP_LOAD && full)
      |=> (count_ff == $past(count_ff)))
      else $error("body count changed on a dropped load");

   // Only stored bodies are ever read.
   a_read_below_count: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> ({1'b0, mem_rd_addr} < {1'b0, count_ff}))
      else $error("body table read beyond the body count");

   // The sequencer never reads and writes the table in the same cycle.
   a_no_read_write_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("body table read and write overlap");

   // Handing over a final result returns the sequencer to idle.
   a_last_ends_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && res_ff.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept working after the final result");

endmodule
